// ===== rtl/jsu_pkg.sv =====
package jsu_pkg;

	// Decoder phase codes.
	localparam logic [3:0] PH_BODY     = 4'd0;
	localparam logic [3:0] PH_ESC      = 4'd1;
	localparam logic [3:0] PH_HEX1     = 4'd2;
	localparam logic [3:0] PH_HEX4     = 4'd5;
	localparam logic [3:0] PH_LOW_BS   = 4'd6;
	localparam logic [3:0] PH_LOW_U    = 4'd7;
	localparam logic [3:0] PH_LOW_HEX1 = 4'd8;
	localparam logic [3:0] PH_LOW_HEX4 = 4'd11;

	// Result status codes.
	localparam logic [1:0] ST_BYTE  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	// Error codes.
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_UNTERM_ESC   = 4'd1;
	localparam logic [3:0] ERR_SHORT_HEX    = 4'd2;
	localparam logic [3:0] ERR_BAD_HEX      = 4'd3;
	localparam logic [3:0] ERR_BAD_LOW      = 4'd4;
	localparam logic [3:0] ERR_MISSING_LOW  = 4'd5;
	localparam logic [3:0] ERR_LONE_LOW     = 4'd6;
	localparam logic [3:0] ERR_BAD_ESC      = 4'd7;
	localparam logic [3:0] ERR_CONTROL      = 4'd8;
	localparam logic [3:0] ERR_UNTERM_STR   = 4'd9;

	// Characters of interest.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

	typedef struct packed {
		logic [3:0]  phase;
		logic [15:0] hex_accum;
		logic [9:0]  high_half;
		logic        finished;
	} state_t;

	// All results caused by one item; data[0] goes out first.
	typedef struct packed {
		logic [2:0]      count;
		logic [3:0][7:0] data;
		logic [1:0]      status;
		logic [3:0]      error_code;
	} result_t;

	function automatic result_t fail_res(input logic [3:0] code);
		result_t r;
		r = '0;
		r.count = 3'd1;
		r.status = ST_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic result_t byte_res(input logic [7:0] b);
		result_t r;
		r = '0;
		r.count = 3'd1;
		r.data[0] = b;
		r.status = ST_BYTE;
		return r;
	endfunction

	// Returns {valid, value} for one ASCII hex digit.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		logic [4:0] v;
		v = '0;
		t = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			v = {1'b1, t[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			v = {1'b1, t[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			v = {1'b1, t[3:0]};
		end
		return v;
	endfunction

	function automatic result_t utf8_encode(input logic [20:0] cp);
		result_t r;
		r = '0;
		r.status = ST_BYTE;
		if (cp <= 21'h7F) begin
			r.count = 3'd1;
			r.data[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			r.count = 3'd2;
			r.data[0] = 8'hC0 | {3'b0, cp[10:6]};
			r.data[1] = 8'h80 | {2'b0, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			r.count = 3'd3;
			r.data[0] = 8'hE0 | {4'b0, cp[15:12]};
			r.data[1] = 8'h80 | {2'b0, cp[11:6]};
			r.data[2] = 8'h80 | {2'b0, cp[5:0]};
		end else begin
			r.count = 3'd4;
			r.data[0] = 8'hF0 | {5'b0, cp[20:18]};
			r.data[1] = 8'h80 | {2'b0, cp[17:12]};
			r.data[2] = 8'h80 | {2'b0, cp[11:6]};
			r.data[3] = 8'h80 | {2'b0, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/jsu_step.sv =====
module jsu_step (
	input  jsu_pkg::state_t  cur,
	input  logic [7:0]       in_byte,
	input  logic             text_end,
	input  logic             first_of_string,
	output jsu_pkg::state_t  nxt,
	output jsu_pkg::result_t res
);

	jsu_pkg::state_t s;
	logic [4:0]      hd;
	logic [15:0]     acc;
	logic [20:0]     cp_pair;

	always_comb begin
		s = cur;
		if (first_of_string) begin
			s = '0;
		end
		hd = jsu_pkg::hex_digit(in_byte);
		acc = {s.hex_accum[11:0], hd[3:0]};
		cp_pair = jsu_pkg::CP_SUPP_BASE + {1'b0, s.high_half, 10'b0} + {11'b0, acc[9:0]};
		nxt = s;
		res = '0;

		if (s.finished) begin
			// Input is dropped until the next string starts.
		end else if (text_end) begin
			nxt.finished = 1'b1;
			case (s.phase)
				jsu_pkg::PH_BODY:   res = jsu_pkg::fail_res(jsu_pkg::ERR_UNTERM_STR);
				jsu_pkg::PH_ESC:    res = jsu_pkg::fail_res(jsu_pkg::ERR_UNTERM_ESC);
				jsu_pkg::PH_LOW_BS,
				jsu_pkg::PH_LOW_U:  res = jsu_pkg::fail_res(jsu_pkg::ERR_MISSING_LOW);
				default:            res = jsu_pkg::fail_res(jsu_pkg::ERR_SHORT_HEX);
			endcase
		end else begin
			case (s.phase)
				jsu_pkg::PH_BODY: begin
					if (in_byte == jsu_pkg::CH_QUOTE) begin
						nxt.finished = 1'b1;
						res.count = 3'd1;
						res.status = jsu_pkg::ST_DONE;
					end else if (in_byte == jsu_pkg::CH_BSL) begin
						nxt.phase = jsu_pkg::PH_ESC;
					end else if (in_byte < jsu_pkg::CH_SPACE) begin
						nxt.finished = 1'b1;
						res = jsu_pkg::fail_res(jsu_pkg::ERR_CONTROL);
					end else begin
						// Bytes of 0x80 and above pass through as they are.
						res = jsu_pkg::byte_res(in_byte);
					end
				end
				jsu_pkg::PH_ESC: begin
					nxt.phase = jsu_pkg::PH_BODY;
					case (in_byte)
						jsu_pkg::CH_QUOTE: res = jsu_pkg::byte_res(jsu_pkg::CH_QUOTE);
						jsu_pkg::CH_BSL:   res = jsu_pkg::byte_res(jsu_pkg::CH_BSL);
						jsu_pkg::CH_SLASH: res = jsu_pkg::byte_res(jsu_pkg::CH_SLASH);
						jsu_pkg::CH_B:     res = jsu_pkg::byte_res(8'h08);
						jsu_pkg::CH_F:     res = jsu_pkg::byte_res(8'h0C);
						jsu_pkg::CH_N:     res = jsu_pkg::byte_res(8'h0A);
						jsu_pkg::CH_R:     res = jsu_pkg::byte_res(8'h0D);
						jsu_pkg::CH_T:     res = jsu_pkg::byte_res(8'h09);
						jsu_pkg::CH_U: begin
							nxt.phase = jsu_pkg::PH_HEX1;
							nxt.hex_accum = '0;
						end
						default: begin
							nxt.finished = 1'b1;
							res = jsu_pkg::fail_res(jsu_pkg::ERR_BAD_ESC);
						end
					endcase
				end
				jsu_pkg::PH_LOW_BS: begin
					if (in_byte != jsu_pkg::CH_BSL) begin
						nxt.finished = 1'b1;
						res = jsu_pkg::fail_res(jsu_pkg::ERR_MISSING_LOW);
					end else begin
						nxt.phase = jsu_pkg::PH_LOW_U;
					end
				end
				jsu_pkg::PH_LOW_U: begin
					if (in_byte != jsu_pkg::CH_U) begin
						nxt.finished = 1'b1;
						res = jsu_pkg::fail_res(jsu_pkg::ERR_MISSING_LOW);
					end else begin
						nxt.phase = jsu_pkg::PH_LOW_HEX1;
						nxt.hex_accum = '0;
					end
				end
				default: begin
					if (s.phase > jsu_pkg::PH_LOW_HEX4) begin
						nxt.phase = jsu_pkg::PH_BODY;
					end else if (!hd[4]) begin
						nxt.finished = 1'b1;
						res = jsu_pkg::fail_res(jsu_pkg::ERR_BAD_HEX);
					end else begin
						nxt.hex_accum = acc;
						if (s.phase == jsu_pkg::PH_HEX4) begin
							if (acc >= jsu_pkg::SURR_HI_MIN && acc <= jsu_pkg::SURR_HI_MAX) begin
								nxt.high_half = acc[9:0];
								nxt.phase = jsu_pkg::PH_LOW_BS;
							end else begin
								nxt.phase = jsu_pkg::PH_BODY;
								if (acc >= jsu_pkg::SURR_LO_MIN && acc <= jsu_pkg::SURR_LO_MAX) begin
									nxt.finished = 1'b1;
									res = jsu_pkg::fail_res(jsu_pkg::ERR_LONE_LOW);
								end else begin
									res = jsu_pkg::utf8_encode({5'b0, acc});
								end
							end
						end else if (s.phase == jsu_pkg::PH_LOW_HEX4) begin
							nxt.phase = jsu_pkg::PH_BODY;
							if (acc < jsu_pkg::SURR_LO_MIN || acc > jsu_pkg::SURR_LO_MAX) begin
								nxt.finished = 1'b1;
								res = jsu_pkg::fail_res(jsu_pkg::ERR_BAD_LOW);
							end else begin
								res = jsu_pkg::utf8_encode(cp_pair);
							end
						end else begin
							nxt.phase = s.phase + 4'd1;
						end
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// Decodes a JSON string body to UTF-8, one input byte per item. Each accepted item is
// decoded in the cycle it is taken and its results (none, one decoded byte, a done or
// an error result, or two to four UTF-8 bytes of a \u escape) land in a result register
// that presents one result per cycle while out_ready is high. The next item is accepted
// in the same cycle that the last pending result leaves; an item with several results
// holds off the input while the result register drains. After a done or error result,
// items give nothing until first_of_string is set.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       text_end,
	input  logic       first_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic [3:0] error_code,
	output logic       last
);

	jsu_pkg::state_t  state_q;
	jsu_pkg::state_t  state_next;
	jsu_pkg::result_t step_res;

	logic [3:0][7:0] data_q;
	logic [1:0]      status_q;
	logic [3:0]      code_q;
	logic [2:0]      cnt_q;
	logic [1:0]      idx_q;
	logic            in_fire;
	logic            out_fire;

	jsu_step u_step (
		.cur             (state_q),
		.in_byte         (in_byte),
		.text_end        (text_end),
		.first_of_string (first_of_string),
		.nxt             (state_next),
		.res             (step_res)
	);

	assign out_valid  = (cnt_q != 3'd0);
	assign out_fire   = out_valid && out_ready;
	assign in_ready   = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready);
	assign in_fire    = in_valid && in_ready;
	assign out_byte   = data_q[idx_q];
	assign status     = status_q;
	assign error_code = code_q;
	assign last       = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (in_fire) begin
				state_q <= state_next;
				cnt_q   <= step_res.count;
				idx_q   <= '0;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 3'd1;
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q   <= step_res.data;
			status_q <= step_res.status;
			code_q   <= step_res.error_code;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 210;
	localparam int STALL_LIMIT = 2000;
	localparam int RUN_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] st;
		logic [3:0] code;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [7:0] b;
		logic       te;
		logic       fs;
		logic       chk;
		logic [1:0] st;
		logic [3:0] code;
		logic [7:0] ob;
	} stim_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       text_end = 1'b0;
	logic       first_of_string = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic [3:0] error_code;
	logic       last;

	json_string_unescape_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.text_end(text_end),
		.first_of_string(first_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.status(status),
		.error_code(error_code),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state mirrored by the predictor.
	logic [3:0]  dec_phase = jsu_pkg::PH_BODY;
	logic [15:0] dec_accum = '0;
	logic [9:0]  dec_high = '0;
	logic        dec_finished = 1'b0;

	out_t  step_out [0:3];
	int    step_n;
	out_t  expected_out [$];
	stim_t plan_q [$];

	int    mismatches = 0;
	int    live_items = 0;
	int    idle_cycles = 0;
	int    run_cycles = 0;
	int    rdy_left = 0;
	logic  calm = 1'b0;
	logic  next_fs = 1'b0;
	logic  cur_chk = 1'b0;
	out_t  cur_exp;
	out_t  got;
	out_t  want;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return int'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66)
			return int'(c - 8'h61) + 10;
		if (c >= 8'h41 && c <= 8'h46)
			return int'(c - 8'h41) + 10;
		return -1;
	endfunction

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic put_res(input logic [7:0] b, input logic [1:0] st, input logic [3:0] code);
		step_out[step_n] = {b, st, code, 1'b0};
		step_n++;
	endtask

	task automatic fail_decode(input logic [3:0] code);
		dec_finished = 1'b1;
		put_res(8'h00, jsu_pkg::ST_ERROR, code);
	endtask

	task automatic encode_utf8(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			put_res(cp[7:0], jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
		end else if (cp <= 21'h7FF) begin
			put_res({3'b110, cp[10:6]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
			put_res({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
		end else if (cp <= 21'hFFFF) begin
			put_res({4'b1110, cp[15:12]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
			put_res({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
			put_res({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
		end else begin
			put_res({5'b11110, cp[20:18]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
			put_res({2'b10, cp[17:12]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
			put_res({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
			put_res({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
		end
	endtask

	// Works out every result one accepted item causes, in order, into step_out.
	task automatic predict_decode(input logic [7:0] c, input logic te, input logic fs);
		int d;
		logic [15:0] v;
		logic [20:0] cp;
		step_n = 0;
		if (fs) begin
			dec_phase = jsu_pkg::PH_BODY;
			dec_accum = '0;
			dec_high = '0;
			dec_finished = 1'b0;
		end
		if (dec_finished)
			return;
		if (te) begin
			if (dec_phase == jsu_pkg::PH_BODY)
				fail_decode(jsu_pkg::ERR_UNTERM_STR);
			else if (dec_phase == jsu_pkg::PH_ESC)
				fail_decode(jsu_pkg::ERR_UNTERM_ESC);
			else if (dec_phase == jsu_pkg::PH_LOW_BS || dec_phase == jsu_pkg::PH_LOW_U)
				fail_decode(jsu_pkg::ERR_MISSING_LOW);
			else
				fail_decode(jsu_pkg::ERR_SHORT_HEX);
		end else begin
			case (dec_phase)
				jsu_pkg::PH_BODY: begin
					if (c == jsu_pkg::CH_QUOTE) begin
						dec_finished = 1'b1;
						put_res(8'h00, jsu_pkg::ST_DONE, jsu_pkg::ERR_NONE);
					end else if (c == jsu_pkg::CH_BSL) begin
						dec_phase = jsu_pkg::PH_ESC;
					end else if (c < jsu_pkg::CH_SPACE) begin
						fail_decode(jsu_pkg::ERR_CONTROL);
					end else begin
						// Raw bytes, high ones included, go out as they came.
						put_res(c, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
					end
				end
				jsu_pkg::PH_ESC: begin
					dec_phase = jsu_pkg::PH_BODY;
					case (c)
						jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH:
							put_res(c, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_B: put_res(8'h08, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_F: put_res(8'h0C, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_N: put_res(8'h0A, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_R: put_res(8'h0D, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_T: put_res(8'h09, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE);
						jsu_pkg::CH_U: begin
							dec_phase = jsu_pkg::PH_HEX1;
							dec_accum = '0;
						end
						default: fail_decode(jsu_pkg::ERR_BAD_ESC);
					endcase
				end
				jsu_pkg::PH_LOW_BS: begin
					if (c != jsu_pkg::CH_BSL)
						fail_decode(jsu_pkg::ERR_MISSING_LOW);
					else
						dec_phase = jsu_pkg::PH_LOW_U;
				end
				jsu_pkg::PH_LOW_U: begin
					if (c != jsu_pkg::CH_U) begin
						fail_decode(jsu_pkg::ERR_MISSING_LOW);
					end else begin
						dec_phase = jsu_pkg::PH_LOW_HEX1;
						dec_accum = '0;
					end
				end
				default: begin
					d = hex_nibble(c);
					if (dec_phase > jsu_pkg::PH_LOW_HEX4) begin
						dec_phase = jsu_pkg::PH_BODY;
					end else if (d < 0) begin
						fail_decode(jsu_pkg::ERR_BAD_HEX);
					end else begin
						dec_accum = {dec_accum[11:0], 4'(d)};
						v = dec_accum;
						if (dec_phase == jsu_pkg::PH_HEX4) begin
							if (v >= jsu_pkg::SURR_HI_MIN && v <= jsu_pkg::SURR_HI_MAX) begin
								dec_high = 10'(v - jsu_pkg::SURR_HI_MIN);
								dec_phase = jsu_pkg::PH_LOW_BS;
							end else begin
								dec_phase = jsu_pkg::PH_BODY;
								if (v >= jsu_pkg::SURR_LO_MIN && v <= jsu_pkg::SURR_LO_MAX)
									fail_decode(jsu_pkg::ERR_LONE_LOW);
								else
									encode_utf8({5'b0, v});
							end
						end else if (dec_phase == jsu_pkg::PH_LOW_HEX4) begin
							dec_phase = jsu_pkg::PH_BODY;
							if (v < jsu_pkg::SURR_LO_MIN || v > jsu_pkg::SURR_LO_MAX) begin
								fail_decode(jsu_pkg::ERR_BAD_LOW);
							end else begin
								cp = jsu_pkg::CP_SUPP_BASE + {1'b0, dec_high, 10'b0}
									+ {5'b0, 16'(v - jsu_pkg::SURR_LO_MIN)};
								encode_utf8(cp);
							end
						end else begin
							dec_phase = dec_phase + 4'd1;
						end
					end
				end
			endcase
		end
		if (step_n != 0)
			step_out[step_n - 1].last = 1'b1;
	endtask

	// Directed rows: one with the result written out, one left to the predictor.
	task automatic row_chk(input logic [7:0] b, input logic te, input logic fs,
		input logic [1:0] st, input logic [3:0] code, input logic [7:0] ob);
		plan_q.insert(plan_q.size(), {b, te, fs, 1'b1, st, code, ob});
		live_items++;
	endtask

	task automatic row_pred(input logic [7:0] b, input logic te, input logic fs);
		plan_q.insert(plan_q.size(),
			{b, te, fs, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'h00});
		live_items++;
	endtask

	task automatic add_item(input logic [7:0] b, input logic te);
		plan_q.insert(plan_q.size(),
			{b, te, next_fs, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'h00});
		next_fs = 1'b0;
		live_items++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + {4'b0, v};
		if ($urandom_range(0, 1))
			return 8'h61 + {4'b0, v} - 8'd10;
		return 8'h41 + {4'b0, v} - 8'd10;
	endfunction

	task automatic add_u4(input logic [15:0] v);
		add_item(jsu_pkg::CH_BSL, 1'b0);
		add_item(jsu_pkg::CH_U, 1'b0);
		for (int i = 3; i >= 0; i--)
			add_item(hex_char(v[i*4 +: 4]), 1'b0);
	endtask

	function automatic logic [7:0] escape_char();
		case ($urandom_range(0, 7))
			0: return jsu_pkg::CH_QUOTE;
			1: return jsu_pkg::CH_BSL;
			2: return jsu_pkg::CH_SLASH;
			3: return jsu_pkg::CH_B;
			4: return jsu_pkg::CH_F;
			5: return jsu_pkg::CH_N;
			6: return jsu_pkg::CH_R;
			default: return jsu_pkg::CH_T;
		endcase
	endfunction

	task automatic add_token();
		int r;
		logic [7:0] b;
		logic [15:0] v;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			b = 8'($urandom_range(8'h20, 8'h7E));
			if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL)
				b = 8'h61;
			add_item(b, 1'b0);
		end else if (r < 40) begin
			add_item(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
		end else if (r < 55) begin
			add_item(jsu_pkg::CH_BSL, 1'b0);
			add_item(escape_char(), 1'b0);
		end else if (r < 75) begin
			case ($urandom_range(0, 3))
				0: v = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(0, 16'h7F));
				1: v = 16'($urandom_range(16'h80, 16'h7FF));
				default: v = 16'($urandom_range(16'h800, 16'hFFFF));
			endcase
			if (v >= jsu_pkg::SURR_HI_MIN && v <= jsu_pkg::SURR_LO_MAX)
				v = v ^ 16'h4000;
			add_u4(v);
		end else if (r < 90) begin
			add_u4(jsu_pkg::SURR_HI_MIN + 16'($urandom_range(0, 1023)));
			add_u4(jsu_pkg::SURR_LO_MIN + 16'($urandom_range(0, 1023)));
		end else begin
			add_item(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	// Partial \u escape: either the first one or the low half after a high surrogate.
	task automatic add_partial_hex();
		if ($urandom_range(0, 1)) begin
			add_u4(jsu_pkg::SURR_HI_MIN + 16'($urandom_range(0, 1023)));
		end
		add_item(jsu_pkg::CH_BSL, 1'b0);
		add_item(jsu_pkg::CH_U, 1'b0);
		repeat ($urandom_range(0, 3))
			add_item(hex_char(4'($urandom_range(0, 15))), 1'b0);
	endtask

	task automatic add_error(input logic [3:0] code);
		logic [7:0] b;
		logic [15:0] v;
		case (code)
			jsu_pkg::ERR_UNTERM_ESC: begin
				add_item(jsu_pkg::CH_BSL, 1'b0);
				add_item(8'($urandom_range(0, 255)), 1'b1);
			end
			jsu_pkg::ERR_SHORT_HEX: begin
				add_partial_hex();
				add_item(8'($urandom_range(0, 255)), 1'b1);
			end
			jsu_pkg::ERR_BAD_HEX: begin
				add_partial_hex();
				do
					b = 8'($urandom_range(0, 255));
				while (hex_nibble(b) >= 0);
				add_item(b, 1'b0);
			end
			jsu_pkg::ERR_BAD_LOW: begin
				add_u4(jsu_pkg::SURR_HI_MIN + 16'($urandom_range(0, 1023)));
				v = 16'($urandom_range(0, 16'hFFFF));
				if (v >= jsu_pkg::SURR_LO_MIN && v <= jsu_pkg::SURR_LO_MAX)
					v = v ^ 16'h4000;
				add_u4(v);
			end
			jsu_pkg::ERR_MISSING_LOW: begin
				add_u4(jsu_pkg::SURR_HI_MIN + 16'($urandom_range(0, 1023)));
				case ($urandom_range(0, 3))
					0: begin
						b = 8'($urandom_range(0, 255));
						if (b == jsu_pkg::CH_BSL)
							b = jsu_pkg::CH_U;
						add_item(b, 1'b0);
					end
					1: begin
						add_item(jsu_pkg::CH_BSL, 1'b0);
						b = 8'($urandom_range(0, 255));
						if (b == jsu_pkg::CH_U)
							b = jsu_pkg::CH_BSL;
						add_item(b, 1'b0);
					end
					2: add_item(8'($urandom_range(0, 255)), 1'b1);
					default: begin
						add_item(jsu_pkg::CH_BSL, 1'b0);
						add_item(8'($urandom_range(0, 255)), 1'b1);
					end
				endcase
			end
			jsu_pkg::ERR_LONE_LOW:
				add_u4(jsu_pkg::SURR_LO_MIN + 16'($urandom_range(0, 1023)));
			jsu_pkg::ERR_BAD_ESC: begin
				add_item(jsu_pkg::CH_BSL, 1'b0);
				do
					b = 8'($urandom_range(0, 255));
				while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL
					|| b == jsu_pkg::CH_SLASH || b == jsu_pkg::CH_B
					|| b == jsu_pkg::CH_F || b == jsu_pkg::CH_N
					|| b == jsu_pkg::CH_R || b == jsu_pkg::CH_T || b == jsu_pkg::CH_U);
				add_item(b, 1'b0);
			end
			jsu_pkg::ERR_CONTROL: add_item(8'($urandom_range(0, 8'h1F)), 1'b0);
			default: add_item(8'($urandom_range(0, 255)), 1'b1);
		endcase
	endtask

	// One string body: a few tokens, then a closing quote, an error, or nothing at all,
	// in which case the next string's first item cuts it off.
	task automatic build_string();
		int r;
		logic closed;
		next_fs = 1'b1;
		calm = ($urandom_range(0, 5) == 0);
		repeat ($urandom_range(0, 6))
			add_token();
		r = $urandom_range(0, 99);
		closed = 1'b1;
		if (r < 55)
			add_item(jsu_pkg::CH_QUOTE, 1'b0);
		else if (r < 62)
			closed = 1'b0;
		else
			add_error(4'($urandom_range(1, 9)));
		// A finished string swallows whatever follows until the next string begins.
		if (closed && !next_fs && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				plan_q.insert(plan_q.size(),
					{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'b0, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'h00});
				live_items++;
			end
		end
	endtask

	task automatic send_item(input stim_t s);
		int g;
		in_byte <= s.b;
		text_end <= s.te;
		first_of_string <= s.fs;
		in_valid <= 1'b1;
		cur_chk = s.chk;
		cur_exp = {s.ob, s.st, s.code, 1'b1};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		g = calm ? 0 : gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	always @(negedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
			rdy_left = 0;
		end else if (rdy_left != 0) begin
			rdy_left--;
		end else if (out_ready) begin
			rdy_left = gap_len();
			if (rdy_left != 0) begin
				out_ready <= 1'b0;
				rdy_left--;
			end
		end else begin
			out_ready <= 1'b1;
			rdy_left = $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_decode(in_byte, text_end, first_of_string);
				if (cur_chk) begin
					expected_out.insert(expected_out.size(), cur_exp);
				end else begin
					for (int i = 0; i < step_n; i++)
						expected_out.insert(expected_out.size(), step_out[i]);
				end
			end
			if (out_valid && out_ready) begin
				got = {out_byte, status, error_code, last};
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf(
						"unexpected result byte=%02h status=%0d code=%0d last=%0b",
						got.data, got.st, got.code, got.last));
				end else begin
					want = expected_out.pop_front();
					if (got.data !== want.data || got.st !== want.st
						|| got.code !== want.code || got.last !== want.last)
						report_mismatch($sformatf(
							"got byte=%02h status=%0d code=%0d last=%0b, want %02h/%0d/%0d/%0b",
							got.data, got.st, got.code, got.last,
							want.data, want.st, want.code, want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		run_cycles++;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT || run_cycles >= RUN_LIMIT) begin
			$display("watchdog: run stopped after %0d cycles", run_cycles);
			$display("json_string_unescape_utf8 verification failed");
			$finish;
		end
	end

	initial begin
		// Plain bytes at the edges of the raw range, then a control byte ends the string.
		row_chk(8'h41, 1'b0, 1'b1, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'h41);
		row_chk(8'hFF, 1'b0, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'hFF);
		row_chk(8'h80, 1'b0, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'h80);
		row_chk(8'h7F, 1'b0, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'h7F);
		row_chk(jsu_pkg::CH_SPACE, 1'b0, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE,
			jsu_pkg::CH_SPACE);
		row_chk(8'h1F, 1'b0, 1'b0, jsu_pkg::ST_ERROR, jsu_pkg::ERR_CONTROL, 8'h00);
		// Finished: neither a byte nor the end of text gives anything.
		row_pred(8'h78, 1'b0, 1'b0);
		row_pred(8'h00, 1'b1, 1'b0);
		// A surrogate pair, joined into four bytes.
		row_pred(jsu_pkg::CH_BSL, 1'b0, 1'b1);
		row_pred(jsu_pkg::CH_U, 1'b0, 1'b0);
		row_pred(8'h44, 1'b0, 1'b0);
		row_pred(8'h38, 1'b0, 1'b0);
		row_pred(8'h33, 1'b0, 1'b0);
		row_pred(8'h64, 1'b0, 1'b0);
		row_pred(jsu_pkg::CH_BSL, 1'b0, 1'b0);
		row_pred(jsu_pkg::CH_U, 1'b0, 1'b0);
		row_pred(8'h44, 1'b0, 1'b0);
		row_pred(8'h45, 1'b0, 1'b0);
		row_pred(8'h30, 1'b0, 1'b0);
		row_pred(8'h30, 1'b0, 1'b0);
		// An escaped zero still comes out as a decoded byte.
		row_pred(jsu_pkg::CH_BSL, 1'b0, 1'b1);
		row_pred(jsu_pkg::CH_U, 1'b0, 1'b0);
		row_pred(8'h30, 1'b0, 1'b0);
		row_pred(8'h30, 1'b0, 1'b0);
		row_pred(8'h30, 1'b0, 1'b0);
		row_chk(8'h30, 1'b0, 1'b0, jsu_pkg::ST_BYTE, jsu_pkg::ERR_NONE, 8'h00);
		row_chk(jsu_pkg::CH_QUOTE, 1'b0, 1'b1, jsu_pkg::ST_DONE, jsu_pkg::ERR_NONE, 8'h00);
		row_chk(8'hFF, 1'b1, 1'b1, jsu_pkg::ST_ERROR, jsu_pkg::ERR_UNTERM_STR, 8'h00);
		row_pred(jsu_pkg::CH_BSL, 1'b0, 1'b1);
		row_chk(8'h00, 1'b1, 1'b0, jsu_pkg::ST_ERROR, jsu_pkg::ERR_UNTERM_ESC, 8'h00);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		while (plan_q.size() != 0)
			send_item(plan_q.pop_front());
		while (live_items < ITEM_TARGET) begin
			build_string();
			while (plan_q.size() != 0)
				send_item(plan_q.pop_front());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("json_string_unescape_utf8 verification clean");
		else
			$display("json_string_unescape_utf8 verification failed");
		$finish;
	end

endmodule
